[rtl/lsegt_pkg.sv]
package lsegt_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DEC,
    ST_PF_RD,
    ST_PF_ACC,
    ST_PF_MLO,
    ST_PF_MHI,
    ST_PF_FIN,
    ST_OUT,
    ST_SETD,
    ST_UP_INIT,
    ST_UP_MLO,
    ST_UP_MHI,
    ST_UP_RD,
    ST_UP_WR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic cap;
    logic pf_init;
    logic pf_lo;
    logic rd;
    logic pf_acc;
    logic mul_lo;
    logic mul_hi;
    logic mul_d;
    logic pf_fin;
    logic pf_first;
    logic set_d;
    logic up_init;
    logic up_hi;
    logic up_wr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic i_zero;
    logic i_over;
    logic empty;
    op_t  op;
  } sts_t;

endpackage

[rtl/lsegt_dp.sv]
module lsegt_dp
  import lsegt_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [10:0] n_used,
  input  logic [1:0]  in_op,
  input  logic [10:0] in_left,
  input  logic [10:0] in_right,
  input  logic [31:0] in_value,
  output logic [63:0] range_sum
);

  localparam int IW    = $clog2(2 * LEAVES + 1);
  localparam int AW    = $clog2(LEAVES + 1);
  localparam int DEPTH = LEAVES + 1;
  localparam int CW    = (IW > 12) ? IW : 12;

  // Two Fenwick arrays share one word: upper half is the slope term,
  // lower half the offset term. prefix(x) = x * sum(slope) - sum(offset).
  logic [127:0] mem [DEPTH];
  logic [127:0] rdata_r;

  logic [IW-1:0] i_r, x_r, a_r, b_r;
  logic [63:0]   acc1_r, acc2_r, prod_r, p_r, d_r;
  logic [31:0]   v_r;
  logic          neg_r, empty_r;
  op_t           op_r;

  logic [CW-1:0] left_w, right_w, top_w, a_w, b_w;
  logic          load_ok;
  logic [IW-1:0] low_w, x_nxt;
  logic [63:0]   vext_w, t_w, mop_w, dl1_w, dl2_w;
  logic [127:0]  wdata_w;
  logic          we_w;

  always_comb begin
    left_w  = CW'(in_left);
    right_w = CW'(in_right);
    top_w   = (CW'(n_used) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(n_used);
    a_w     = (left_w == '0) ? CW'(1) : left_w;
    b_w     = (right_w > top_w) ? top_w : right_w;
    load_ok = (left_w != '0) && (left_w <= top_w);
  end

  assign low_w   = i_r & (~i_r + IW'(1));
  assign vext_w  = {{32{v_r[31]}}, v_r};
  assign t_w     = prod_r - acc2_r;
  assign mop_w   = cmd.mul_d ? d_r : acc1_r;
  assign x_nxt   = cmd.pf_lo ? (a_r - IW'(1)) : b_r;
  assign dl1_w   = neg_r ? (64'd0 - d_r) : d_r;
  assign dl2_w   = neg_r ? (64'd0 - prod_r) : prod_r;
  assign we_w    = cmd.clr | cmd.up_wr;
  assign wdata_w = cmd.clr ? 128'd0
                 : {rdata_r[127:64] + dl1_w, rdata_r[63:0] + dl2_w};

  always_ff @(posedge clk) begin
    if (we_w) begin
      mem[i_r[AW-1:0]] <= wdata_w;
    end
    if (cmd.rd) begin
      rdata_r <= mem[i_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
    end else if (cmd.clr) begin
      i_r <= i_r + IW'(1);
    end else if (cmd.pf_init) begin
      i_r <= x_nxt;
    end else if (cmd.pf_acc) begin
      i_r <= i_r - low_w;
    end else if (cmd.up_init) begin
      i_r <= cmd.up_hi ? (b_r + IW'(1)) : a_r;
    end else if (cmd.up_wr) begin
      i_r <= i_r + low_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r <= op_t'(in_op);
      v_r  <= in_value;
      p_r  <= '0;
      if (op_t'(in_op) == OP_LOAD) begin
        a_r     <= left_w[IW-1:0];
        b_r     <= left_w[IW-1:0];
        empty_r <= !load_ok;
      end else begin
        a_r     <= a_w[IW-1:0];
        b_r     <= b_w[IW-1:0];
        empty_r <= a_w > b_w;
      end
    end
    if (cmd.pf_fin) begin
      p_r <= cmd.pf_first ? t_w : (p_r - t_w);
    end
    if (cmd.pf_init) begin
      x_r    <= x_nxt;
      acc1_r <= '0;
      acc2_r <= '0;
    end
    if (cmd.pf_acc) begin
      acc1_r <= acc1_r + rdata_r[127:64];
      acc2_r <= acc2_r + rdata_r[63:0];
    end
    if (cmd.mul_lo) begin
      prod_r <= 64'(mop_w[31:0] * x_r);
    end
    if (cmd.mul_hi) begin
      prod_r <= prod_r + {32'(mop_w[63:32] * x_r), 32'd0};
    end
    if (cmd.set_d) begin
      d_r <= (op_r == OP_LOAD) ? (vext_w - p_r) : vext_w;
    end
    if (cmd.up_init) begin
      x_r   <= cmd.up_hi ? b_r : (a_r - IW'(1));
      neg_r <= cmd.up_hi;
    end
  end

  assign sts.clr_done = (i_r == IW'(DEPTH - 1));
  assign sts.i_zero   = (i_r == '0);
  assign sts.i_over   = (i_r > IW'(LEAVES));
  assign sts.empty    = empty_r;
  assign sts.op       = op_r;
  assign range_sum    = p_r;

endmodule

[rtl/lsegt_ctrl.sv]
module lsegt_ctrl
  import lsegt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  state_t state_r, state_nxt;
  logic   pass_r, pass_nxt;
  logic   upd_r, upd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      pass_r  <= 1'b0;
      upd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      upd_r   <= upd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    upd_nxt   = upd_r;
    unique case (state_r)
      ST_CLR:     if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:    if (start) state_nxt = ST_DEC;
      ST_DEC: begin
        pass_nxt = 1'b0;
        priority if (sts.op == OP_QUERY) begin
          state_nxt = sts.empty ? ST_OUT : ST_PF_RD;
        end else if (sts.op == OP_LOAD) begin
          state_nxt = sts.empty ? ST_IDLE : ST_PF_RD;
        end else if (sts.op == OP_ADD) begin
          state_nxt = sts.empty ? ST_IDLE : ST_SETD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PF_RD:   state_nxt = sts.i_zero ? ST_PF_MLO : ST_PF_ACC;
      ST_PF_ACC:  state_nxt = ST_PF_RD;
      ST_PF_MLO:  state_nxt = ST_PF_MHI;
      ST_PF_MHI:  state_nxt = ST_PF_FIN;
      ST_PF_FIN: begin
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_PF_RD;
        end else begin
          state_nxt = (sts.op == OP_QUERY) ? ST_OUT : ST_SETD;
        end
      end
      ST_OUT:     state_nxt = ST_IDLE;
      ST_SETD: begin
        upd_nxt   = 1'b0;
        state_nxt = ST_UP_INIT;
      end
      ST_UP_INIT: state_nxt = ST_UP_MLO;
      ST_UP_MLO:  state_nxt = ST_UP_MHI;
      ST_UP_MHI:  state_nxt = ST_UP_RD;
      ST_UP_RD: begin
        if (sts.i_over) begin
          upd_nxt   = 1'b1;
          state_nxt = upd_r ? ST_IDLE : ST_UP_INIT;
        end else begin
          state_nxt = ST_UP_WR;
        end
      end
      ST_UP_WR:   state_nxt = ST_UP_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLR:  cmd.clr = 1'b1;
      ST_IDLE: begin
        busy    = 1'b0;
        cmd.cap = start;
      end
      ST_DEC: begin
        if (!sts.empty && (sts.op == OP_QUERY || sts.op == OP_LOAD)) begin
          cmd.pf_init = 1'b1;
        end
      end
      ST_PF_RD:   cmd.rd = !sts.i_zero;
      ST_PF_ACC:  cmd.pf_acc = 1'b1;
      ST_PF_MLO:  cmd.mul_lo = 1'b1;
      ST_PF_MHI:  cmd.mul_hi = 1'b1;
      ST_PF_FIN: begin
        cmd.pf_fin   = 1'b1;
        cmd.pf_first = !pass_r;
        if (!pass_r) begin
          cmd.pf_init = 1'b1;
          cmd.pf_lo   = 1'b1;
        end
      end
      ST_OUT:     out_valid = 1'b1;
      ST_SETD:    cmd.set_d = 1'b1;
      ST_UP_INIT: begin
        cmd.up_init = 1'b1;
        cmd.up_hi   = upd_r;
      end
      ST_UP_MLO: begin
        cmd.mul_lo = 1'b1;
        cmd.mul_d  = 1'b1;
      end
      ST_UP_MHI: begin
        cmd.mul_hi = 1'b1;
        cmd.mul_d  = 1'b1;
      end
      ST_UP_RD:   cmd.rd = !sts.i_over;
      ST_UP_WR:   cmd.up_wr = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

endmodule

[rtl/lazy_segment_tree_range_add_sum.sv]
// Channel   Handshake               Payload
// input     start / busy            in_op, in_left, in_right, in_value
// result    out_valid (strobe)      out_range_sum
// config    cfg_valid / cfg_ready   cfg_data (n_used)
//
// Range sums are kept as two Fenwick arrays in one memory, one access per cycle.
// A non-empty query takes two prefix walks.
// A non-empty add takes two update walks after setup, each step a read and a write; a load both.
// After reset every memory word is cleared with busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module lazy_segment_tree_range_add_sum
  import lsegt_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [10:0] in_left,
  input  logic [10:0] in_right,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [63:0] out_range_sum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  cmd_t        cmd;
  sts_t        sts;
  logic [10:0] n_used_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_used_r <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      n_used_r <= cfg_data;
    end
  end

  lsegt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lsegt_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .n_used    (n_used_r),
    .in_op     (in_op),
    .in_left   (in_left),
    .in_right  (in_right),
    .in_value  (in_value),
    .range_sum (out_range_sum)
  );

endmodule

[rtl/lsegt_chk.sv]
module lsegt_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A result beat only comes while an item is in work.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat repeated");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> busy) else $error("no clearing pass after reset");

endmodule

bind lazy_segment_tree_range_add_sum lsegt_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
